FILE: rtl/residue_table_generator_adjoin_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the residue table generator core
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef RESIDUE_TABLE_GENERATOR_ADJOIN_CORE_ASSERT_SVH
`define RESIDUE_TABLE_GENERATOR_ADJOIN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rtga_pkg.sv
// ----------------------------------------------------------------------------
// rtga_pkg
// Types and fixed constants shared by the residue table generator modules.
// ----------------------------------------------------------------------------
package rtga_pkg;

  localparam int GEN_W     = 20;
  localparam int CNT_W     = $clog2(GEN_W);
  localparam int CFG_W     = 7;
  localparam int MAX_OUT_W = 32;
  localparam int SUM_OUT_W = 38;

  localparam logic [CFG_W-1:0]     MOD_RESET = 7'd20;
  localparam logic [CFG_W-1:0]     MOD_MIN   = 7'd2;
  localparam logic [SUM_OUT_W-1:0] SUM_MAX   = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHK_RD,
    ST_CHK,
    ST_LOAD,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

FILE: rtl/rtga_alu.sv
// ----------------------------------------------------------------------------
// rtga_alu
// Shared add/subtract unit: trial subtraction for the residue computation and
// saturating addition for the table relaxation.
// ----------------------------------------------------------------------------
module rtga_alu #(
  parameter int W  = 33,
  parameter int VW = 32
) (
  input  rtga_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      res,
  output logic              ge,
  output logic [VW-1:0]     sat
);

  logic [W:0] full;
  logic [W:0] marker_ext;
  logic       is_sub;

  assign is_sub     = (op == rtga_pkg::ALU_SUB);
  assign marker_ext = (W+1)'({VW{1'b1}});

  always_comb begin
    full = {1'b0, a} + {1'b0, (is_sub ? ~b : b)} + (W+1)'(is_sub);
  end

  assign res = full[W-1:0];
  // In subtract mode the carry out means a >= b.
  assign ge  = full[W];
  // Any sum that reaches the unreachable marker is clamped to it.
  assign sat = (full >= marker_ext) ? {VW{1'b1}} : full[VW-1:0];

endmodule

FILE: rtl/rtga_table.sv
// ----------------------------------------------------------------------------
// rtga_table
// Residue table memory with one write and one registered read per cycle,
// per-entry valid bits for the restart value and write-to-read bypass.
// ----------------------------------------------------------------------------
module rtga_table #(
  parameter int DEPTH = 64,
  parameter int VW    = 32,
  parameter int IW    = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtga_pkg::tbl_ctl_t ctl,
  input  logic [IW-1:0]      rd_addr,
  input  logic [IW-1:0]      wr_addr,
  input  logic [VW-1:0]      wr_data,
  output logic [VW-1:0]      rd_data
);

  logic [VW-1:0]    mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [VW-1:0]    rd_raw_r;
  logic [VW-1:0]    byp_data_r;
  logic             byp_r;
  logic             vld_q_r;
  logic             zero_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_raw_r   <= mem_r[rd_addr];
      byp_r      <= ctl.wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
      vld_q_r    <= valid_r[rd_addr];
      zero_q_r   <= (rd_addr == '0);
    end
  end

  // An entry never written since restart reads as its origin value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clear) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    if (byp_r) begin
      rd_data = byp_data_r;
    end else if (vld_q_r) begin
      rd_data = rd_raw_r;
    end else if (zero_q_r) begin
      rd_data = '0;
    end else begin
      rd_data = {VW{1'b1}};
    end
  end

endmodule

FILE: rtl/residue_table_generator_adjoin_core.sv
// ----------------------------------------------------------------------------
// residue_table_generator_adjoin_core
// Keeps the smallest representable value per residue modulo the configured
// modulus m and adjoins one generator per input word. An item passes through
// the bit-serial residue computation, the redundancy lookup, then one
// relaxation step per cycle on the residue table (two laps of every residue
// cycle, with a load step at each cycle start), and the finishing of the
// running statistics. The input stalls for that whole time; a finished
// result waits in the output register while the next word is taken.
// Restart clears the table at once through its valid bits; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module residue_table_generator_adjoin_core #(
  parameter int MAX_MODULUS = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rtga_pkg::GEN_W-1:0]         in_generator,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_redundant,
  output logic                               out_all_reachable,
  output logic [rtga_pkg::MAX_OUT_W-1:0]     out_max_value,
  output logic [rtga_pkg::SUM_OUT_W-1:0]     out_value_sum,
  input  logic                               cfg_wr_en,
  input  logic [rtga_pkg::CFG_W-1:0]         cfg_wr_data
);

  localparam int VW   = VALUE_WIDTH;
  localparam int IW   = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
  localparam int NW   = IW + 1;
  localparam int AW   = ((VW > rtga_pkg::GEN_W) ? VW : rtga_pkg::GEN_W) + 1;
  localparam int ACCW = ((VW > rtga_pkg::SUM_OUT_W) ? VW : rtga_pkg::SUM_OUT_W) + 1;
  localparam int MXW  = (VW > rtga_pkg::MAX_OUT_W) ? VW : rtga_pkg::MAX_OUT_W;
  localparam logic [VW-1:0] MARKER = {VW{1'b1}};

  rtga_pkg::state_t state_r, state_nxt;

  logic [rtga_pkg::CFG_W-1:0]     modulus_r, modulus_nxt;
  logic [rtga_pkg::GEN_W-1:0]     gen_r, gen_nxt;
  logic [rtga_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NW-1:0]                  m_r, m_nxt;
  logic [NW-1:0]                  rem_r, rem_nxt;
  logic [NW-1:0]                  s_r, s_nxt;
  logic [NW-1:0]                  r_r, r_nxt;
  logic [NW-1:0]                  g_r, g_nxt;
  logic                           ret_r, ret_nxt;
  logic [VW-1:0]                  cur_r, cur_nxt;
  logic                           redundant_r, redundant_nxt;
  logic                           st_en_r, st_en_nxt;
  logic [VW-1:0]                  st_val_r, st_val_nxt;
  logic [rtga_pkg::SUM_OUT_W-1:0] acc_r, acc_nxt;
  logic [VW-1:0]                  max_r, max_nxt;
  logic                           allok_r, allok_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_red_r, out_red_nxt;
  logic                           out_all_r, out_all_nxt;
  logic [rtga_pkg::MAX_OUT_W-1:0] out_max_r, out_max_nxt;
  logic [rtga_pkg::SUM_OUT_W-1:0] out_sum_r, out_sum_nxt;

  logic                  accept;
  logic                  load_out;
  logic [NW-1:0]         m_clamp;
  logic [NW-1:0]         trial;
  logic [NW-1:0]         base;
  logic [NW:0]           nsum;
  logic [NW-1:0]         nxt_res;
  logic [NW-1:0]         s_inc;
  logic                  hit;
  logic                  last;
  logic                  more;
  logic                  red_now;
  logic [VW-1:0]         new_val;
  logic [ACCW-1:0]       sum_wide;
  logic [rtga_pkg::SUM_OUT_W-1:0] acc_sat;
  logic [MXW-1:0]        max_ext;
  logic [rtga_pkg::MAX_OUT_W-1:0] max_sat;

  rtga_pkg::alu_op_t  alu_op;
  logic [AW-1:0]      alu_a;
  logic [AW-1:0]      alu_b;
  logic [AW-1:0]      alu_res;
  logic               alu_ge;
  logic [VW-1:0]      alu_sat;

  rtga_pkg::tbl_ctl_t tbl_ctl;
  logic [IW-1:0]      tbl_rd_addr;
  logic [VW-1:0]      tbl_rd_data;

  assign accept   = (state_r == rtga_pkg::ST_IDLE) && in_valid;
  assign load_out = (state_r == rtga_pkg::ST_FINISH) && (!out_valid_r || !out_stall);

  // Modulus outside the supported range is pulled to the nearest bound.
  always_comb begin
    if (modulus_r < rtga_pkg::MOD_MIN) begin
      m_clamp = NW'(rtga_pkg::MOD_MIN);
    end else if (int'(modulus_r) > MAX_MODULUS) begin
      m_clamp = NW'(MAX_MODULUS);
    end else begin
      m_clamp = NW'(modulus_r);
    end
  end

  // Next residue along the translation cycle: (base + step) mod m.
  assign base    = (state_r == rtga_pkg::ST_LOAD) ? s_r : r_r;
  assign nsum    = (NW+1)'(base) + (NW+1)'(rem_r);
  assign nxt_res = (nsum >= (NW+1)'(m_r)) ? NW'(nsum - (NW+1)'(m_r)) : NW'(nsum);

  assign trial = {rem_r[IW-1:0], gen_r[cnt_r]};
  assign s_inc = s_r + NW'(1);
  assign hit   = (r_r == s_r);
  assign last  = hit && ret_r;
  assign more  = (s_inc < g_r);

  assign alu_op = (state_r == rtga_pkg::ST_MOD) ? rtga_pkg::ALU_SUB : rtga_pkg::ALU_ADD;
  assign alu_a  = (state_r == rtga_pkg::ST_MOD) ? AW'(trial) : AW'(cur_r);
  assign alu_b  = (state_r == rtga_pkg::ST_MOD) ? AW'(m_r) : AW'(gen_r);

  rtga_alu #(
    .W  (AW),
    .VW (VW)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge),
    .sat (alu_sat)
  );

  rtga_table #(
    .DEPTH (MAX_MODULUS),
    .VW    (VW),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .rd_addr (tbl_rd_addr),
    .wr_addr (r_r[IW-1:0]),
    .wr_data (new_val),
    .rd_data (tbl_rd_data)
  );

  assign new_val = (alu_sat < tbl_rd_data) ? alu_sat : tbl_rd_data;
  assign red_now = (tbl_rd_data != MARKER) && (AW'(tbl_rd_data) <= AW'(gen_r));

  // Statistics follow the relaxation by one register, on final table values.
  assign sum_wide = ACCW'(acc_r) + ACCW'(st_val_r);
  assign acc_sat  = (sum_wide > ACCW'(rtga_pkg::SUM_MAX)) ?
                    rtga_pkg::SUM_MAX : sum_wide[rtga_pkg::SUM_OUT_W-1:0];
  assign max_ext  = MXW'(max_r);
  assign max_sat  = (max_ext > MXW'({rtga_pkg::MAX_OUT_W{1'b1}})) ?
                    {rtga_pkg::MAX_OUT_W{1'b1}} : max_ext[rtga_pkg::MAX_OUT_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtga_pkg::ST_IDLE: begin
        if (accept) state_nxt = rtga_pkg::ST_MOD;
      end
      rtga_pkg::ST_MOD: begin
        if (cnt_r == '0) state_nxt = rtga_pkg::ST_CHK_RD;
      end
      rtga_pkg::ST_CHK_RD: state_nxt = rtga_pkg::ST_CHK;
      rtga_pkg::ST_CHK:    state_nxt = rtga_pkg::ST_LOAD;
      rtga_pkg::ST_LOAD:   state_nxt = rtga_pkg::ST_WALK;
      rtga_pkg::ST_WALK: begin
        if (last) state_nxt = more ? rtga_pkg::ST_LOAD : rtga_pkg::ST_DRAIN;
      end
      rtga_pkg::ST_DRAIN:  state_nxt = rtga_pkg::ST_FINISH;
      rtga_pkg::ST_FINISH: begin
        if (load_out) state_nxt = rtga_pkg::ST_IDLE;
      end
      default: state_nxt = rtga_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and table port control.
  always_comb begin
    in_stall      = 1'b1;
    tbl_ctl.clear = 1'b0;
    tbl_ctl.rd_en = 1'b0;
    tbl_ctl.wr_en = 1'b0;
    tbl_rd_addr   = nxt_res[IW-1:0];
    case (state_r)
      rtga_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        tbl_ctl.clear = accept && in_restart;
      end
      rtga_pkg::ST_CHK_RD: begin
        tbl_ctl.rd_en = 1'b1;
        tbl_rd_addr   = rem_r[IW-1:0];
      end
      rtga_pkg::ST_CHK: begin
        tbl_ctl.rd_en = 1'b1;
        tbl_rd_addr   = s_r[IW-1:0];
      end
      rtga_pkg::ST_LOAD: begin
        tbl_ctl.rd_en = 1'b1;
      end
      rtga_pkg::ST_WALK: begin
        tbl_ctl.wr_en = 1'b1;
        tbl_ctl.rd_en = !last || more;
        if (last) tbl_rd_addr = s_inc[IW-1:0];
      end
      default: begin
        tbl_ctl.rd_en = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    modulus_nxt   = cfg_wr_en ? cfg_wr_data : modulus_r;
    gen_nxt       = gen_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    rem_nxt       = rem_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    g_nxt         = g_r;
    ret_nxt       = ret_r;
    cur_nxt       = cur_r;
    redundant_nxt = redundant_r;
    acc_nxt       = acc_r;
    max_nxt       = max_r;
    allok_nxt     = allok_r;
    st_en_nxt     = (state_r == rtga_pkg::ST_WALK) && ret_r;
    st_val_nxt    = new_val;

    if (st_en_r) begin
      acc_nxt = acc_sat;
      if (st_val_r > max_r) max_nxt = st_val_r;
      if (st_val_r == MARKER) allok_nxt = 1'b0;
    end

    case (state_r)
      rtga_pkg::ST_IDLE: begin
        if (accept) begin
          gen_nxt   = in_generator;
          m_nxt     = m_clamp;
          cnt_nxt   = rtga_pkg::CNT_W'(rtga_pkg::GEN_W - 1);
          rem_nxt   = '0;
          s_nxt     = '0;
          acc_nxt   = '0;
          max_nxt   = '0;
          allok_nxt = 1'b1;
        end
      end
      rtga_pkg::ST_MOD: begin
        // Restoring reduction, one generator bit per cycle, msb first.
        rem_nxt = alu_ge ? NW'(alu_res) : trial;
        cnt_nxt = cnt_r - rtga_pkg::CNT_W'(1);
      end
      rtga_pkg::ST_CHK: begin
        redundant_nxt = red_now;
        ret_nxt       = 1'b0;
        g_nxt         = m_r;
      end
      rtga_pkg::ST_LOAD: begin
        cur_nxt = tbl_rd_data;
        r_nxt   = nxt_res;
      end
      rtga_pkg::ST_WALK: begin
        cur_nxt = new_val;
        // The smallest nonzero residue on the cycle through zero is the gcd,
        // which is also the number of residue cycles to walk.
        if ((s_r == '0) && !ret_r && (r_r != '0) && (r_r < g_r)) g_nxt = r_r;
        if (last) begin
          if (more) begin
            s_nxt   = s_inc;
            ret_nxt = 1'b0;
          end
        end else begin
          r_nxt = nxt_res;
          if (hit) ret_nxt = 1'b1;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = (out_valid_r && out_stall) || load_out;
    out_red_nxt   = out_red_r;
    out_all_nxt   = out_all_r;
    out_max_nxt   = out_max_r;
    out_sum_nxt   = out_sum_r;
    if (load_out) begin
      out_red_nxt = redundant_r;
      out_all_nxt = allok_r;
      out_max_nxt = max_sat;
      out_sum_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtga_pkg::ST_IDLE;
      modulus_r   <= rtga_pkg::MOD_RESET;
      out_valid_r <= 1'b0;
      st_en_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
      st_en_r     <= st_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_r       <= gen_nxt;
    cnt_r       <= cnt_nxt;
    m_r         <= m_nxt;
    rem_r       <= rem_nxt;
    s_r         <= s_nxt;
    r_r         <= r_nxt;
    g_r         <= g_nxt;
    ret_r       <= ret_nxt;
    cur_r       <= cur_nxt;
    redundant_r <= redundant_nxt;
    st_val_r    <= st_val_nxt;
    acc_r       <= acc_nxt;
    max_r       <= max_nxt;
    allok_r     <= allok_nxt;
    out_red_r   <= out_red_nxt;
    out_all_r   <= out_all_nxt;
    out_max_r   <= out_max_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_redundant     = out_red_r;
  assign out_all_reachable = out_all_r;
  assign out_max_value     = out_max_r;
  assign out_value_sum     = out_sum_r;

endmodule

FILE: rtl/rtga_checker.sv
// ----------------------------------------------------------------------------
// rtga_checker
// Port-level checks on the residue table generator core, bound to the top.
// ----------------------------------------------------------------------------
`include "residue_table_generator_adjoin_core_assert.svh"

module rtga_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_all_reachable,
  input logic [rtga_pkg::MAX_OUT_W-1:0]     out_max_value,
  input logic [rtga_pkg::SUM_OUT_W-1:0]     out_value_sum
);

  // Largest value the max output can show when some residue is unreachable.
  localparam logic [rtga_pkg::MAX_OUT_W-1:0] UNREACH_MAX =
    (VALUE_WIDTH >= rtga_pkg::MAX_OUT_W) ? {rtga_pkg::MAX_OUT_W{1'b1}} :
    rtga_pkg::MAX_OUT_W'((64'd1 << VALUE_WIDTH) - 64'd1);

  `RTGA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "word accepted but input not stalled next cycle")

  `RTGA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_max_value) && $stable(out_value_sum), "stalled result word changed")

  `RTGA_ASSERT_NOW(a_unreach_max, out_valid && !out_all_reachable, out_max_value == UNREACH_MAX, "unreachable residue but max is not the marker")

  `RTGA_ASSERT_NOW(a_sum_ge_max, out_valid, out_value_sum >= rtga_pkg::SUM_OUT_W'(out_max_value), "sum of entries below the largest entry")

  `RTGA_ASSERT_NOW(a_result_while_busy, $rose(out_valid), $past(in_stall), "result word appeared without an item in work")

endmodule

bind residue_table_generator_adjoin_core rtga_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_rtga_checker (.*);
